>>> sv/assert_macros.svh
// assertion macros shared by the rtl that carries checks
// expects a clock named clk and an active-low reset named rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge, off while reset is low
`define FSP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// plain condition checked on every rising edge, off while reset is low
`define FSP_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> sv/fsp_pkg.sv
// shared types and constants for the fixed slot pool allocator
// no dependencies
package fsp_pkg;

  localparam int SLOT_W    = 10;
  localparam int OFFSET_W  = 26;
  localparam int STATUS_W  = 2;
  localparam int CAP_OUT_W = 11;
  localparam int PAGE_W    = 11;
  localparam int BYTES_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic CMD_ACQUIRE = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_REJECT    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SLOTS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_BYTES = 2'd1;

  localparam logic [PAGE_W-1:0]  PAGE_SLOTS_RST = 11'd16;
  localparam logic [BYTES_W-1:0] SLOT_BYTES_RST = 16'd16;

  typedef struct packed {
    logic              command;
    logic [SLOT_W-1:0] slot_in;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0]    slot_out;
    logic [OFFSET_W-1:0]  byte_offset;
    logic [STATUS_W-1:0]  status;
    logic [CAP_OUT_W-1:0] capacity;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic execute;
  } ctl_t;

endpackage

>>> sv/fsp_ctrl.sv
// controller state machine for the slot pool allocator
// depends on fsp_pkg
module fsp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  output logic          out_valid,
  output fsp_pkg::ctl_t ctl
);
  import fsp_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state_r;
  logic   out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          out_valid_r <= 1'b0;
          if (start) begin
            state_r <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          out_valid_r <= 1'b1;
          state_r     <= ST_IDLE;
        end
        default: begin
          out_valid_r <= 1'b0;
          state_r     <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy        = (state_r == ST_EXEC);
  assign out_valid   = out_valid_r;
  assign ctl.capture = start && (state_r == ST_IDLE);
  assign ctl.execute = (state_r == ST_EXEC);

endmodule

>>> sv/fsp_datapath.sv
// datapath of the slot pool allocator: config, free list, link memory, offset multiply
// depends on fsp_pkg
module fsp_datapath #(
  parameter int MAX_SLOTS = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [fsp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fsp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  fsp_pkg::in_item_t               in_item,
  input  fsp_pkg::ctl_t                   ctl,
  output fsp_pkg::out_item_t              out_item
);
  import fsp_pkg::*;

  localparam int CAP_W  = $clog2(MAX_SLOTS + 1);
  localparam int DEPTH  = (MAX_SLOTS < (1 << SLOT_W)) ? MAX_SLOTS : (1 << SLOT_W);
  localparam int AW     = $clog2(DEPTH);
  localparam int CMP_W  = (CAP_W > SLOT_W) ? CAP_W : SLOT_W;
  localparam int SUM_W  = ((CAP_W > PAGE_W) ? CAP_W : PAGE_W) + 1;
  localparam int PROD_W = CAP_W + BYTES_W;

  logic [PAGE_W-1:0]  page_slots_r;
  logic [BYTES_W-1:0] slot_bytes_r;
  logic [SLOT_W-1:0]  head_r, head_nxt;
  logic               nonempty_r, nonempty_nxt;
  logic [CAP_W-1:0]   fresh_r, fresh_nxt;
  logic [CAP_W-1:0]   cap_r, cap_nxt;

  logic               cmd_r;
  logic [SLOT_W-1:0]  slot_in_r;
  logic [SLOT_W-1:0]  link_rd_r;
  logic [SLOT_W-1:0]  link_mem [DEPTH];
  out_item_t          out_r;

  logic                    release_ok, reject, need_grow, exhausted, pop;
  logic [PAGE_W-1:0]       grow;
  logic [SUM_W-1:0]        new_cap;
  logic [CAP_W-1:0]        slot_full;
  logic [CAP_W-1:0]        mul_slot;
  logic [STATUS_W-1:0]     status;
  logic [PROD_W-1:0]       prod;
  logic [PROD_W+OFFSET_W-1:0] prod_ext;
  logic [CAP_W+CAP_OUT_W-1:0] cap_ext;
  logic [CAP_W+SLOT_W-1:0]    slot_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_slots_r <= PAGE_SLOTS_RST;
      slot_bytes_r <= SLOT_BYTES_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PAGE_SLOTS: page_slots_r <= cfg_data[PAGE_W-1:0];
        CFG_SLOT_BYTES: slot_bytes_r <= cfg_data[BYTES_W-1:0];
        default: ;
      endcase
    end
  end

  // capture the item and fetch the link behind the current head
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r     <= in_item.command;
      slot_in_r <= in_item.slot_in;
      link_rd_r <= link_mem[head_r[AW-1:0]];
    end
  end

  always_comb begin
    grow      = (page_slots_r == '0) ? PAGE_W'(1) : page_slots_r;
    new_cap   = SUM_W'(cap_r) + SUM_W'(grow);
    need_grow = (fresh_r >= cap_r);
    reject    = (cmd_r == CMD_RELEASE) &&
                (CMP_W'(slot_in_r) >= CMP_W'(cap_r));
    release_ok = (cmd_r == CMD_RELEASE) && !reject;
    pop       = (cmd_r == CMD_ACQUIRE) && nonempty_r;
    exhausted = (cmd_r == CMD_ACQUIRE) && !nonempty_r && need_grow &&
                (new_cap > SUM_W'(MAX_SLOTS));

    head_nxt     = head_r;
    nonempty_nxt = nonempty_r;
    fresh_nxt    = fresh_r;
    cap_nxt      = cap_r;
    slot_full    = '0;
    mul_slot     = '0;
    status       = STATUS_OK;

    priority if (reject) begin
      slot_full = CAP_W'(slot_in_r);
      status    = STATUS_REJECT;
    end else if (release_ok) begin
      head_nxt     = slot_in_r;
      nonempty_nxt = 1'b1;
      slot_full    = CAP_W'(slot_in_r);
      mul_slot     = CAP_W'(slot_in_r);
    end else if (pop) begin
      // a self link marks the tail of the list
      if (link_rd_r == head_r) begin
        head_nxt     = '0;
        nonempty_nxt = 1'b0;
      end else begin
        head_nxt = link_rd_r;
      end
      slot_full = CAP_W'(head_r);
      mul_slot  = CAP_W'(head_r);
    end else if (exhausted) begin
      status = STATUS_EXHAUSTED;
    end else begin
      if (need_grow) begin
        cap_nxt = new_cap[CAP_W-1:0];
      end
      fresh_nxt = fresh_r + CAP_W'(1);
      slot_full = fresh_r;
      mul_slot  = fresh_r;
    end

    prod     = PROD_W'(mul_slot) * PROD_W'(slot_bytes_r);
    prod_ext = {{OFFSET_W{1'b0}}, prod};
    cap_ext  = {{CAP_OUT_W{1'b0}}, cap_nxt};
    slot_ext = {{SLOT_W{1'b0}}, slot_full};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      nonempty_r <= 1'b0;
      fresh_r    <= '0;
      cap_r      <= '0;
    end else if (ctl.execute) begin
      head_r     <= head_nxt;
      nonempty_r <= nonempty_nxt;
      fresh_r    <= fresh_nxt;
      cap_r      <= cap_nxt;
    end
  end

  // push links the released slot to the old head, or to itself on an empty list
  always_ff @(posedge clk) begin
    if (ctl.execute && release_ok) begin
      link_mem[slot_in_r[AW-1:0]] <= nonempty_r ? head_r : slot_in_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.execute) begin
      out_r.slot_out    <= slot_ext[SLOT_W-1:0];
      out_r.byte_offset <= prod_ext[OFFSET_W-1:0];
      out_r.status      <= status;
      out_r.capacity    <= cap_ext[CAP_OUT_W-1:0];
    end
  end

  assign out_item = out_r;

endmodule

>>> sv/fixed_slot_pool_allocator.sv
// top level of the fixed slot pool allocator
// depends on fsp_pkg, fsp_ctrl, fsp_datapath and assert_macros.svh
// a command taken while idle is captured, executed in ST_EXEC, then its result is registered and strobed
// no new command is taken while the previous one executes and busy is high
// reset: synchronous active low, empty pool, capacity 0, page_slots and slot_bytes back to 16
// the result strobe lasts one cycle and cannot be held off by the receiver
module fixed_slot_pool_allocator #(
  parameter int MAX_SLOTS = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // command channel
  input  logic                            start,
  output logic                            busy,
  input  fsp_pkg::in_item_t               in_item,
  // result channel
  output logic                            out_valid,
  output fsp_pkg::out_item_t              out_item,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fsp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fsp_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import fsp_pkg::*;

`include "assert_macros.svh"

  ctl_t ctl;
  logic cfg_we;

  // config transfers are taken only when no command is in flight or being offered
  assign cfg_ready = !busy && !start;
  assign cfg_we    = cfg_valid && cfg_ready;

  // sequencer: idle, then an execute state per command
  fsp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .ctl       (ctl)
  );

  // free list head, fresh pointer, capacity, link memory and offset multiply
  fsp_datapath #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .ctl       (ctl),
    .out_item  (out_item)
  );

  // every accepted command is followed by its result strobe
  `FSP_ASSERT(a_result_follows, start && !busy |-> ##2 out_valid, "missing result strobe")
  // the result cycle never overlaps an executing command
  `FSP_ASSERT_NEVER(a_strobe_idle, out_valid && busy, "result strobe while busy")
  // an exhausted pool reports slot and offset zero
  `FSP_ASSERT(a_exhausted_zero,
    out_valid && out_item.status == STATUS_EXHAUSTED |->
      out_item.slot_out == '0 && out_item.byte_offset == '0,
    "exhausted result carries a slot")

endmodule

>>> dv/fixed_slot_pool_allocator_tb.sv
// self-checking testbench for the fixed slot pool allocator
// depends on fsp_pkg and the fixed_slot_pool_allocator rtl, nothing else
// directed table first, then random command phases under several register settings
module fixed_slot_pool_allocator_tb;
  import fsp_pkg::*;

  localparam int POOL_SLOTS  = 1024;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 105;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_item = '0;
  logic out_valid;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // typed expectation riding along with the command, sampled at the accepting edge
  bit has_typed = 1'b0;
  out_item_t typed_want = '0;

  always #5 clk = ~clk;

  fixed_slot_pool_allocator #(
    .MAX_SLOTS(POOL_SLOTS)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_item(out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // pool mirror: link memory, free-list head, fresh pointer and capacity
  logic [SLOT_W-1:0] pool_link [POOL_SLOTS];
  logic [SLOT_W-1:0] pool_head = '0;
  bit pool_live = 1'b0;
  int pool_fresh = 0;
  int pool_cap = 0;
  logic [PAGE_W-1:0] pool_page = PAGE_SLOTS_RST;
  logic [BYTES_W-1:0] pool_bytes = SLOT_BYTES_RST;

  out_item_t predicted_outcomes[$];
  logic [SLOT_W-1:0] held_slots[$];

  int fail_count = 0;
  int cycles = 0;
  int n_acquire = 0;
  int n_release = 0;
  int n_ok = 0;
  int n_exhausted = 0;
  int n_reject = 0;

  // outcome of one command against the mirror, updating the mirror as the block would
  function automatic out_item_t pool_outcome(in_item_t it);
    out_item_t r;
    int grow;
    r = '0;
    r.status = STATUS_OK;
    if (it.command == CMD_RELEASE) begin
      r.slot_out = it.slot_in;
      if (int'(it.slot_in) >= pool_cap) begin
        r.status = STATUS_REJECT;
      end else begin
        // first node on an empty list links to itself, marking the tail
        pool_link[it.slot_in] = pool_live ? pool_head : it.slot_in;
        pool_head = it.slot_in;
        pool_live = 1'b1;
      end
    end else if (pool_live) begin
      r.slot_out = pool_head;
      // self-link ends the list, double release included
      if (pool_link[pool_head] == pool_head) begin
        pool_live = 1'b0;
        pool_head = '0;
      end else begin
        pool_head = pool_link[pool_head];
      end
    end else begin
      if (pool_fresh >= pool_cap) begin
        grow = (pool_page == '0) ? 1 : int'(pool_page);
        if (pool_cap + grow > POOL_SLOTS) begin
          r.status = STATUS_EXHAUSTED;
        end else begin
          pool_cap = pool_cap + grow;
        end
      end
      if (r.status == STATUS_OK) begin
        r.slot_out = SLOT_W'(pool_fresh);
        pool_fresh = pool_fresh + 1;
      end
    end
    if (r.status == STATUS_OK) begin
      r.byte_offset = OFFSET_W'(32'(r.slot_out) * 32'(pool_bytes));
    end
    r.capacity = CAP_OUT_W'(pool_cap);
    return r;
  endfunction

  // watch every edge: register writes, accepted commands, strobed results
  always @(posedge clk) begin : watch
    out_item_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PAGE_SLOTS: pool_page = cfg_data[PAGE_W-1:0];
          CFG_SLOT_BYTES: pool_bytes = cfg_data[BYTES_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        want = pool_outcome(in_item);
        if (in_item.command == CMD_ACQUIRE) begin
          n_acquire++;
          if (want.status == STATUS_OK) held_slots.push_back(want.slot_out);
        end else begin
          n_release++;
        end
        // the predictor still runs on typed rows so the mirror stays in step
        predicted_outcomes.push_back(has_typed ? typed_want : want);
      end
      if (out_valid) begin
        case (out_item.status)
          STATUS_OK: n_ok++;
          STATUS_EXHAUSTED: n_exhausted++;
          default: n_reject++;
        endcase
        if (predicted_outcomes.size() == 0) begin
          $error("result with nothing outstanding: slot_out %0d status %0d",
                 out_item.slot_out, out_item.status);
          fail_count++;
        end else begin
          want = predicted_outcomes.pop_front();
          if (out_item.slot_out !== want.slot_out) begin
            $error("slot_out expected %0d actual %0d", want.slot_out, out_item.slot_out);
            fail_count++;
          end
          if (out_item.byte_offset !== want.byte_offset) begin
            $error("byte_offset expected %0d actual %0d",
                   want.byte_offset, out_item.byte_offset);
            fail_count++;
          end
          if (out_item.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, out_item.status);
            fail_count++;
          end
          if (out_item.capacity !== want.capacity) begin
            $error("capacity expected %0d actual %0d", want.capacity, out_item.capacity);
            fail_count++;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("fixed_slot_pool_allocator verification failed");
      $finish;
    end
  end

  // register write, only once the pool has drained every outstanding result
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    start <= 1'b0;
    @(posedge clk);
    while (predicted_outcomes.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one command transfer; start stays high into the next call unless a gap follows
  task automatic send_cmd(input in_item_t it, input bit typed, input out_item_t want,
                          input bit may_idle);
    if (it.command == CMD_RELEASE) begin
      foreach (held_slots[k]) begin
        if (held_slots[k] == it.slot_in) begin
          held_slots.delete(k);
          break;
        end
      end
    end
    start <= 1'b1;
    in_item <= it;
    has_typed <= typed;
    typed_want <= want;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (may_idle && $urandom_range(3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  typedef struct {
    bit is_cfg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    in_item_t cmd;
    int reps;
    bit typed;
    out_item_t want;
  } plan_row_t;

  plan_row_t stim_plan[$];

  function automatic void plan_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    plan_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.reg_idx = idx;
    row.reg_data = data;
    stim_plan.push_back(row);
  endfunction

  function automatic void plan_cmd(logic cmd, logic [SLOT_W-1:0] slot, int reps, bit typed,
                                   out_item_t want);
    plan_row_t row;
    row = '{default: '0};
    row.cmd.command = cmd;
    row.cmd.slot_in = slot;
    row.reps = reps;
    row.typed = typed;
    row.want = want;
    stim_plan.push_back(row);
  endfunction

  function automatic out_item_t grant(int slot, int offset, logic [STATUS_W-1:0] st, int cap);
    out_item_t r;
    r.slot_out = SLOT_W'(slot);
    r.byte_offset = OFFSET_W'(offset);
    r.status = st;
    r.capacity = CAP_OUT_W'(cap);
    return r;
  endfunction

  initial begin
    in_item_t it;
    int acq_pct;
    logic [PAGE_W-1:0] page;
    logic [BYTES_W-1:0] bytes;

    // directed table, defaults page_slots 16 and slot_bytes 16 out of reset
    // empty pool rejects every release, both ends of the slot range
    plan_cmd(CMD_RELEASE, 10'd0, 1, 1'b1, grant(0, 0, STATUS_REJECT, 0));
    plan_cmd(CMD_RELEASE, 10'd1023, 1, 1'b1, grant(1023, 0, STATUS_REJECT, 0));
    // first acquire grows one default page
    plan_cmd(CMD_ACQUIRE, 10'd0, 1, 1'b1, grant(0, 0, STATUS_OK, 16));
    plan_cmd(CMD_ACQUIRE, 10'd1023, 1, 1'b1, grant(1, 16, STATUS_OK, 16));
    // lifo reuse through the free list, last pop reads the self-link
    plan_cmd(CMD_RELEASE, 10'd1, 1, 1'b0, '0);
    plan_cmd(CMD_RELEASE, 10'd0, 1, 1'b0, '0);
    plan_cmd(CMD_ACQUIRE, 10'd0, 2, 1'b0, '0);
    // release at and just under the capacity boundary
    plan_cmd(CMD_RELEASE, 10'd16, 1, 1'b1, grant(16, 0, STATUS_REJECT, 16));
    plan_cmd(CMD_RELEASE, 10'd15, 1, 1'b1, grant(15, 240, STATUS_OK, 16));
    // double release forms a self-link that ends the list
    plan_cmd(CMD_RELEASE, 10'd15, 1, 1'b0, '0);
    plan_cmd(CMD_ACQUIRE, 10'd0, 1, 1'b0, '0);
    // zero page size grows by a single slot once the fresh slots run out
    plan_cfg(CFG_PAGE_SLOTS, 16'd0);
    plan_cmd(CMD_ACQUIRE, 10'd0, 14, 1'b0, '0);
    plan_cmd(CMD_ACQUIRE, 10'd0, 1, 1'b1, grant(16, 256, STATUS_OK, 17));
    // a full-size page no longer fits: exhausted, state untouched
    plan_cfg(CFG_PAGE_SLOTS, 16'd1024);
    plan_cfg(CFG_SLOT_BYTES, 16'd65535);
    plan_cmd(CMD_ACQUIRE, 10'd0, 1, 1'b1, grant(0, 0, STATUS_EXHAUSTED, 17));
    plan_cmd(CMD_RELEASE, 10'd16, 1, 1'b1, grant(16, 1048560, STATUS_OK, 17));
    plan_cmd(CMD_ACQUIRE, 10'd0, 1, 1'b1, grant(16, 1048560, STATUS_OK, 17));
    plan_cfg(CFG_PAGE_SLOTS, 16'd1);
    plan_cfg(CFG_SLOT_BYTES, 16'd1);
    plan_cmd(CMD_ACQUIRE, 10'd0, 1, 1'b1, grant(17, 17, STATUS_OK, 18));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_plan[r]) begin
      if (stim_plan[r].is_cfg) begin
        write_reg(stim_plan[r].reg_idx, stim_plan[r].reg_data);
      end else begin
        repeat (stim_plan[r].reps)
          send_cmd(stim_plan[r].cmd, stim_plan[r].typed, stim_plan[r].want, 1'b1);
      end
    end

    // random phases, each under its own register setting; extremes come first
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin page = 11'd1; bytes = 16'd65535; end
        1: begin page = 11'd1024; bytes = 16'd1; end
        2: begin page = 11'd0; bytes = 16'd16; end
        default: begin
          page = ($urandom_range(3) == 0) ? PAGE_W'($urandom_range(1, 1024))
                                          : PAGE_W'($urandom_range(1, 40));
          bytes = BYTES_W'($urandom_range(1, 65535));
        end
      endcase
      write_reg(CFG_PAGE_SLOTS, CFG_DATA_W'(page));
      write_reg(CFG_SLOT_BYTES, bytes);
      acq_pct = $urandom_range(35, 80);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        it.command = ($urandom_range(99) < acq_pct) ? CMD_ACQUIRE : CMD_RELEASE;
        // random bits on slot_in always, ignored on acquire
        it.slot_in = SLOT_W'($urandom);
        // mostly hand back a slot that is really held, the rest is noise
        if (it.command == CMD_RELEASE && held_slots.size() != 0 && $urandom_range(9) < 8)
          it.slot_in = held_slots[$urandom_range(held_slots.size() - 1)];
        // final two phases run back to back with no gaps
        send_cmd(it, 1'b0, '0, phase < PHASES - 2);
      end
    end

    // drain, then let the pipeline settle
    start <= 1'b0;
    @(posedge clk);
    while (predicted_outcomes.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("run covered %0d acquires and %0d releases over %0d register settings",
             n_acquire, n_release, PHASES + 4);
    $display("results: %0d ok, %0d exhausted, %0d rejected; capacity reached %0d",
             n_ok, n_exhausted, n_reject, pool_cap);
    if (fail_count == 0) begin
      $display("fixed_slot_pool_allocator verification clean");
    end else begin
      $display("fixed_slot_pool_allocator verification failed");
    end
    $finish;
  end

endmodule
